/* src/udp_multicast_header_builder_core_assert.svh */
// assertion macros for the multicast header builder
`ifndef UDP_MULTICAST_HEADER_BUILDER_CORE_ASSERT_SVH
`define UDP_MULTICAST_HEADER_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UMHB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define UMHB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/umhb_pkg.sv */
// shared types and constants for the multicast header builder
`timescale 1ns / 1ps
`default_nettype none

package umhb_pkg;

	localparam int HDR_BYTES = 42;
	localparam logic [5:0] LAST_INDEX = 6'(HDR_BYTES - 1);
	localparam logic [15:0] MAX_PAYLOAD = 16'd65507;
	localparam logic [15:0] IP_OVERHEAD = 16'd28;
	localparam logic [15:0] UDP_OVERHEAD = 16'd8;
	localparam logic [23:0] MCAST_OUI = 24'h01005e;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0] IP_VER_IHL = 8'h45;
	localparam logic [7:0] IP_TTL = 8'h01;
	localparam logic [7:0] IP_PROTO_UDP = 8'h11;
	localparam logic [3:0] MCAST_PREFIX = 4'he;
	localparam logic [6:0] MCAST_MAC_MASK = 7'h7f;
	// fixed checksum words: version/ihl/tos and ttl/protocol
	localparam logic [15:0] CSUM_FIXED = {IP_VER_IHL, 8'h00} + {IP_TTL, IP_PROTO_UDP};

	localparam logic [1:0] CFG_SOURCE_MAC = 2'd0;
	localparam logic [1:0] CFG_SOURCE_IP = 2'd1;
	localparam logic [1:0] CFG_SOURCE_PORT = 2'd2;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_NOT_MCAST = 2'd1,
		ERR_TOO_LONG = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [15:0] payload_length;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
	} in_item_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [5:0] byte_index;
		logic last_byte;
		logic [1:0] error_code;
	} out_item_t;

	typedef struct packed {
		logic [47:0] source_mac;
		logic [31:0] source_ip;
		logic [15:0] source_port;
	} cfg_t;

	typedef struct packed {
		err_code_t err;
		logic [15:0] ip_len;
		logic [15:0] udp_len;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic [15:0] csum;
	} hdr_fields_t;

endpackage

`default_nettype wire

/* src/udp_multicast_header_builder_core.sv */
// top level: config registers, checksum pipeline and byte serializer
//
// channel   signals                                  direction
// item      item_valid, item_stall, item             in (stall out)
// result    result_valid, result_stall, result       out (stall in)
// config    cfg_we, cfg_index, cfg_data              in
//
// one item gives 42 byte transactions, or one on an error, at one byte a cycle while result_stall is low;
// the serializer sets the rate, so in steady state new items are taken only as fast as headers leave it.
// an accepted item passes through the four checksum stages into the serializer before its first byte goes out.
// reset clears the valid bits, the serializer state and the config registers.
// result_stall freezes the current byte; the pipeline keeps filling behind it
// and item_stall rises once all four stages are full.
`timescale 1ns / 1ps
`default_nettype none
`include "udp_multicast_header_builder_core_assert.svh"

module udp_multicast_header_builder_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [47:0] cfg_data,
	input wire logic item_valid,
	output logic item_stall,
	input wire umhb_pkg::in_item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output umhb_pkg::out_item_t result
);

	umhb_pkg::cfg_t cfg_q;
	logic item_ready;
	logic hdr_valid, hdr_ready;
	umhb_pkg::hdr_fields_t hdr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				umhb_pkg::CFG_SOURCE_MAC: cfg_q.source_mac <= cfg_data;
				umhb_pkg::CFG_SOURCE_IP: cfg_q.source_ip <= cfg_data[31:0];
				umhb_pkg::CFG_SOURCE_PORT: cfg_q.source_port <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	umhb_csum_pipe u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.hdr_valid(hdr_valid),
		.hdr_ready(hdr_ready),
		.hdr(hdr)
	);

	assign item_stall = !item_ready;

	umhb_serializer u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.hdr_valid(hdr_valid),
		.hdr_ready(hdr_ready),
		.hdr(hdr),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// byte positions advance by one within a header
	`UMHB_ASSERT_NEXT(a_index_step, result_valid && !result_stall && !result.last_byte, result_valid && (result.byte_index == $past(result.byte_index) + 6'd1), "byte index did not advance")

	// an error transaction is a single last byte of zero
	`UMHB_ASSERT_NOW(a_err_single, result_valid && (result.error_code != umhb_pkg::ERR_NONE), result.last_byte && (result.header_byte == 8'h00) && (result.byte_index == 6'd0), "malformed error result")

	// the final header byte carries the last mark
	`UMHB_ASSERT_NOW(a_last_at_end, result_valid && (result.byte_index == umhb_pkg::LAST_INDEX), result.last_byte, "last byte mark missing")

endmodule

`default_nettype wire

/* src/umhb_csum_pipe.sv */
// four-stage pipeline: field checks, lengths and ipv4 header checksum
`timescale 1ns / 1ps
`default_nettype none

module umhb_csum_pipe (
	input wire logic clk,
	input wire logic arst_n,
	input wire umhb_pkg::cfg_t cfg,
	input wire logic item_valid,
	output logic item_ready,
	input wire umhb_pkg::in_item_t item,
	output logic hdr_valid,
	input wire logic hdr_ready,
	output umhb_pkg::hdr_fields_t hdr
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	umhb_pkg::hdr_fields_t f_s1, f_s2, f_s3, f_s4;
	logic [17:0] sum_a_s2, sum_b_s2;
	logic [16:0] fold_s3;
	logic [18:0] sum_full;
	umhb_pkg::err_code_t err_in;

	assign rdy4 = !v_s4 || hdr_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign item_ready = rdy1;

	// multicast check wins over the length check
	always_comb begin
		priority if (item.dest_ip[31:28] != umhb_pkg::MCAST_PREFIX) begin
			err_in = umhb_pkg::ERR_NOT_MCAST;
		end else if (item.payload_length > umhb_pkg::MAX_PAYLOAD) begin
			err_in = umhb_pkg::ERR_TOO_LONG;
		end else begin
			err_in = umhb_pkg::ERR_NONE;
		end
	end

	assign sum_full = 19'(sum_a_s2) + 19'(sum_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && item_valid) begin
			f_s1.err <= err_in;
			f_s1.ip_len <= item.payload_length + umhb_pkg::IP_OVERHEAD;
			f_s1.udp_len <= item.payload_length + umhb_pkg::UDP_OVERHEAD;
			f_s1.dest_ip <= item.dest_ip;
			f_s1.dest_port <= item.dest_port;
			f_s1.csum <= '0;
		end
		if (rdy2 && v_s1) begin
			f_s2 <= f_s1;
			sum_a_s2 <= 18'(umhb_pkg::CSUM_FIXED) + 18'(f_s1.ip_len)
				+ 18'(cfg.source_ip[31:16]);
			sum_b_s2 <= 18'(cfg.source_ip[15:0]) + 18'(f_s1.dest_ip[31:16])
				+ 18'(f_s1.dest_ip[15:0]);
		end
		if (rdy3 && v_s2) begin
			f_s3 <= f_s2;
			fold_s3 <= 17'(sum_full[15:0]) + 17'(sum_full[18:16]);
		end
		if (rdy4 && v_s3) begin
			f_s4.err <= f_s3.err;
			f_s4.ip_len <= f_s3.ip_len;
			f_s4.udp_len <= f_s3.udp_len;
			f_s4.dest_ip <= f_s3.dest_ip;
			f_s4.dest_port <= f_s3.dest_port;
			// second fold cannot carry again
			f_s4.csum <= ~(fold_s3[15:0] + 16'(fold_s3[16]));
		end
	end

	assign hdr_valid = v_s4;
	assign hdr = f_s4;

endmodule

`default_nettype wire

/* src/umhb_serializer.sv */
// holds one header and sends it out a byte per transaction
`timescale 1ns / 1ps
`default_nettype none

module umhb_serializer (
	input wire logic clk,
	input wire logic arst_n,
	input wire umhb_pkg::cfg_t cfg,
	input wire logic hdr_valid,
	output logic hdr_ready,
	input wire umhb_pkg::hdr_fields_t hdr,
	output logic result_valid,
	input wire logic result_stall,
	output umhb_pkg::out_item_t result
);

	logic busy_q;
	logic [5:0] cnt_q;
	umhb_pkg::hdr_fields_t hdr_q;
	logic is_err, is_last, take;
	logic [7:0] hbyte;

	assign is_err = hdr_q.err != umhb_pkg::ERR_NONE;
	assign is_last = is_err || (cnt_q == umhb_pkg::LAST_INDEX);
	assign take = busy_q && !result_stall;
	assign hdr_ready = !busy_q || (take && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (hdr_ready && hdr_valid) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (take && is_last) begin
			busy_q <= 1'b0;
		end else if (take) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_ready && hdr_valid) hdr_q <= hdr;
	end

	always_comb begin
		unique case (cnt_q)
			6'd0: hbyte = umhb_pkg::MCAST_OUI[23:16];
			6'd1: hbyte = umhb_pkg::MCAST_OUI[15:8];
			6'd2: hbyte = umhb_pkg::MCAST_OUI[7:0];
			6'd3: hbyte = {1'b0, hdr_q.dest_ip[22:16] & umhb_pkg::MCAST_MAC_MASK};
			6'd4: hbyte = hdr_q.dest_ip[15:8];
			6'd5: hbyte = hdr_q.dest_ip[7:0];
			6'd6: hbyte = cfg.source_mac[47:40];
			6'd7: hbyte = cfg.source_mac[39:32];
			6'd8: hbyte = cfg.source_mac[31:24];
			6'd9: hbyte = cfg.source_mac[23:16];
			6'd10: hbyte = cfg.source_mac[15:8];
			6'd11: hbyte = cfg.source_mac[7:0];
			6'd12: hbyte = umhb_pkg::ETH_TYPE_IPV4[15:8];
			6'd13: hbyte = umhb_pkg::ETH_TYPE_IPV4[7:0];
			6'd14: hbyte = umhb_pkg::IP_VER_IHL;
			6'd16: hbyte = hdr_q.ip_len[15:8];
			6'd17: hbyte = hdr_q.ip_len[7:0];
			6'd22: hbyte = umhb_pkg::IP_TTL;
			6'd23: hbyte = umhb_pkg::IP_PROTO_UDP;
			6'd24: hbyte = hdr_q.csum[15:8];
			6'd25: hbyte = hdr_q.csum[7:0];
			6'd26: hbyte = cfg.source_ip[31:24];
			6'd27: hbyte = cfg.source_ip[23:16];
			6'd28: hbyte = cfg.source_ip[15:8];
			6'd29: hbyte = cfg.source_ip[7:0];
			6'd30: hbyte = hdr_q.dest_ip[31:24];
			6'd31: hbyte = hdr_q.dest_ip[23:16];
			6'd32: hbyte = hdr_q.dest_ip[15:8];
			6'd33: hbyte = hdr_q.dest_ip[7:0];
			6'd34: hbyte = cfg.source_port[15:8];
			6'd35: hbyte = cfg.source_port[7:0];
			6'd36: hbyte = hdr_q.dest_port[15:8];
			6'd37: hbyte = hdr_q.dest_port[7:0];
			6'd38: hbyte = hdr_q.udp_len[15:8];
			6'd39: hbyte = hdr_q.udp_len[7:0];
			// tos, id, flags, udp checksum
			default: hbyte = 8'h00;
		endcase
	end

	assign result_valid = busy_q;
	assign result.header_byte = is_err ? 8'h00 : hbyte;
	assign result.byte_index = is_err ? 6'd0 : cnt_q;
	assign result.last_byte = is_last;
	assign result.error_code = hdr_q.err;

endmodule

`default_nettype wire

/* sim/udp_multicast_header_checker.sv */
// checker for the multicast header builder: predicts every header byte and compares results
`timescale 1ns / 1ps

module udp_multicast_header_checker
	import umhb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [47:0] cfg_data,
	input logic item_valid,
	input logic item_stall,
	input in_item_t item,
	input logic result_valid,
	input logic result_stall,
	input out_item_t result,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned checked
);

	logic [47:0] src_mac;
	logic [31:0] src_ip;
	logic [15:0] src_port;
	out_item_t expected_bytes[$];

	initial begin
		mismatches = 0;
		pending = 0;
		checked = 0;
	end

	task automatic report(input string what);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// queues the bytes (or the single error result) that one request should produce
	function automatic void predict_header(input in_item_t it);
		logic [7:0] hdr [HDR_BYTES];
		logic [15:0] ip_len;
		logic [15:0] udp_len;
		logic [31:0] sum;
		logic [15:0] csum;
		out_item_t r;
		if (it.dest_ip[31:28] != MCAST_PREFIX) begin
			r = '{header_byte: 8'h00, byte_index: 6'd0, last_byte: 1'b1,
				error_code: ERR_NOT_MCAST};
			expected_bytes.push_back(r);
			return;
		end
		if (it.payload_length > MAX_PAYLOAD) begin
			r = '{header_byte: 8'h00, byte_index: 6'd0, last_byte: 1'b1,
				error_code: ERR_TOO_LONG};
			expected_bytes.push_back(r);
			return;
		end
		ip_len = it.payload_length + IP_OVERHEAD;
		udp_len = it.payload_length + UDP_OVERHEAD;
		for (int k = 0; k < HDR_BYTES; k++)
			hdr[k] = 8'h00;
		// ethernet: multicast mac keeps only the low 23 address bits
		hdr[0] = MCAST_OUI[23:16];
		hdr[1] = MCAST_OUI[15:8];
		hdr[2] = MCAST_OUI[7:0];
		hdr[3] = {1'b0, it.dest_ip[22:16] & MCAST_MAC_MASK};
		hdr[4] = it.dest_ip[15:8];
		hdr[5] = it.dest_ip[7:0];
		for (int k = 0; k < 6; k++)
			hdr[6 + k] = src_mac[47 - 8 * k -: 8];
		hdr[12] = ETH_TYPE_IPV4[15:8];
		hdr[13] = ETH_TYPE_IPV4[7:0];
		// ipv4
		hdr[14] = IP_VER_IHL;
		hdr[16] = ip_len[15:8];
		hdr[17] = ip_len[7:0];
		hdr[22] = IP_TTL;
		hdr[23] = IP_PROTO_UDP;
		for (int k = 0; k < 4; k++) begin
			hdr[26 + k] = src_ip[31 - 8 * k -: 8];
			hdr[30 + k] = it.dest_ip[31 - 8 * k -: 8];
		end
		sum = '0;
		for (int k = 14; k < 34; k += 2)
			sum += {16'h0000, hdr[k], hdr[k + 1]};
		while (sum > 32'h0000ffff)
			sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
		csum = ~sum[15:0];
		hdr[24] = csum[15:8];
		hdr[25] = csum[7:0];
		// udp, checksum left at zero
		hdr[34] = src_port[15:8];
		hdr[35] = src_port[7:0];
		hdr[36] = it.dest_port[15:8];
		hdr[37] = it.dest_port[7:0];
		hdr[38] = udp_len[15:8];
		hdr[39] = udp_len[7:0];
		for (int k = 0; k < HDR_BYTES; k++) begin
			r.header_byte = hdr[k];
			r.byte_index = 6'(k);
			r.last_byte = (k == HDR_BYTES - 1);
			r.error_code = ERR_NONE;
			expected_bytes.push_back(r);
		end
	endfunction

	task automatic check_byte(input out_item_t got);
		out_item_t want;
		checked++;
		if (expected_bytes.size() == 0) begin
			report($sformatf("transaction %h with nothing outstanding", got));
			return;
		end
		want = expected_bytes.pop_front();
		if (got.header_byte !== want.header_byte)
			report($sformatf("byte %0d: header_byte %h, want %h",
				want.byte_index, got.header_byte, want.header_byte));
		if (got.byte_index !== want.byte_index)
			report($sformatf("byte_index %0d, want %0d", got.byte_index, want.byte_index));
		if (got.last_byte !== want.last_byte)
			report($sformatf("byte %0d: last_byte %b, want %b",
				want.byte_index, got.last_byte, want.last_byte));
		if (got.error_code !== want.error_code)
			report($sformatf("byte %0d: error_code %0d, want %0d",
				want.byte_index, got.error_code, want.error_code));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_mac <= '0;
			src_ip <= '0;
			src_port <= '0;
			expected_bytes.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SOURCE_MAC: begin
						src_mac <= cfg_data;
					end
					CFG_SOURCE_IP: begin
						src_ip <= cfg_data[31:0];
					end
					CFG_SOURCE_PORT: begin
						src_port <= cfg_data[15:0];
					end
					default: begin
					end
				endcase
			end
			if (result_valid && !result_stall)
				check_byte(result);
			if (item_valid && !item_stall)
				predict_header(item);
			pending <= expected_bytes.size();
		end
	end

endmodule

/* sim/udp_multicast_header_builder_core_tb.sv */
// testbench top for the multicast header builder: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module udp_multicast_header_builder_core_tb;
	import umhb_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned STUCK_LIMIT = 2000;
	localparam int unsigned PIPE_SETTLE = 8;
	localparam int unsigned RANDOM_PHASES = 5;
	localparam int unsigned ITEMS_PER_PHASE = 28;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [47:0] cfg_data;
	logic item_valid;
	logic item_stall;
	in_item_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned checked;

	int unsigned items_sent = 0;
	int unsigned settings_loaded = 0;
	int unsigned stall_left = 0;
	int unsigned stall_draw;
	int unsigned stuck_cycles = 0;
	bit tx_quiet = 1'b1;
	bit rx_quiet = 1'b1;

	udp_multicast_header_builder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	udp_multicast_header_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned draw_wait(input bit quiet);
		if (quiet || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// receiver: after each transaction hold stall for a drawn number of cycles
	always @(posedge clk) begin
		if (result_stall) begin
			if (stall_left <= 1)
				result_stall <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (result_valid) begin
			stall_draw = draw_wait(rx_quiet);
			if (stall_draw != 0) begin
				result_stall <= 1'b1;
				stall_left <= stall_draw;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic in_item_t datagram(input logic [15:0] len, input logic [31:0] dip,
			input logic [15:0] dport);
		in_item_t it;
		it.payload_length = len;
		it.dest_ip = dip;
		it.dest_port = dport;
		return it;
	endfunction

	// mostly valid multicast requests, with some bad addresses and oversize lengths
	function automatic in_item_t random_datagram();
		in_item_t it;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		it.dest_ip = $urandom();
		it.dest_port = 16'($urandom());
		it.payload_length = 16'($urandom_range(0, MAX_PAYLOAD));
		it.dest_ip[31:28] = MCAST_PREFIX;
		if (pick == 0)
			it.payload_length = 16'($urandom_range(MAX_PAYLOAD - 8, MAX_PAYLOAD));
		else if (pick == 1)
			it.payload_length = 16'($urandom_range(0, 64));
		else if (pick == 8) begin
			do
				it.dest_ip[31:28] = 4'($urandom());
			while (it.dest_ip[31:28] == MCAST_PREFIX);
		end else if (pick == 9)
			it.payload_length = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hffff));
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int unsigned gap;
		gap = draw_wait(tx_quiet);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		items_sent++;
	endtask

	// sender holds off until every queued byte has come back
	task automatic drain_results(input int unsigned settle);
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic load_regs(input logic [47:0] mac, input logic [31:0] ip,
			input logic [15:0] port);
		drain_results(PIPE_SETTLE);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SOURCE_MAC;
		cfg_data <= mac;
		@(posedge clk);
		cfg_index <= CFG_SOURCE_IP;
		cfg_data <= {16'($urandom()), ip};
		@(posedge clk);
		cfg_index <= CFG_SOURCE_PORT;
		cfg_data <= {32'($urandom()), port};
		@(posedge clk);
		// unmapped index, must be ignored
		cfg_index <= CFG_UNUSED;
		cfg_data <= 48'({$urandom(), $urandom()});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SOURCE_MAC;
		cfg_data <= '0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset values
		send_item(datagram(16'd0, 32'he0000000, 16'h0000));
		send_item(datagram(MAX_PAYLOAD, 32'hefffffff, 16'hffff));
		send_item(datagram(MAX_PAYLOAD + 16'd1, 32'he1000001, 16'h0101));
		send_item(datagram(16'hffff, 32'hef000000, 16'h8000));
		send_item(datagram(16'd0, 32'hdfffffff, 16'h0001));
		send_item(datagram(16'd100, 32'hf0000000, 16'h0002));
		// bad address and oversize at once: address fault wins
		send_item(datagram(16'hffff, 32'h00000000, 16'h0003));
		send_item(datagram(16'd7, 32'hffffffff, 16'h0004));
		// bit 23 of the group address must not reach the mac
		send_item(datagram(16'd512, 32'he0800000, 16'h1000));
		send_item(datagram(16'd1, 32'hef7fffff, 16'h7fff));
		send_item(datagram(16'd1234, 32'he1020304, 16'h1234));

		load_regs(48'hffffffffffff, 32'hffffffff, 16'hffff);
		send_item(datagram(MAX_PAYLOAD, 32'hefffffff, 16'hffff));
		send_item(datagram(16'd0, 32'he0000000, 16'h0000));
		send_item(datagram(16'd65000, 32'he8f0f0f0, 16'h5a5a));

		// source ip picked so the folded sum is 0xffff and the checksum comes out zero
		load_regs(48'h020000000001, 32'h0000d9d1, 16'h0400);
		send_item(datagram(16'd0, 32'he0000000, 16'h0000));
		send_item(datagram(16'd0, 32'he0000000, 16'hffff));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1: begin
					load_regs(48'hffffffffffff, 32'hffffffff, 16'hffff);
				end
				2: begin
					load_regs(48'h0, 32'h0, 16'h0);
				end
				default: begin
					load_regs(48'({$urandom(), $urandom()}), $urandom(), 16'($urandom()));
				end
			endcase
			tx_quiet = (p == 0) || (p == 2);
			rx_quiet = (p == 0) || (p == 3);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 4 && n == ITEMS_PER_PHASE / 2)
					drain_results(0);
				send_item(random_datagram());
			end
		end

		drain_results(20);
		$display("sent %0d datagram requests over %0d register settings, %0d transactions checked",
			items_sent, settings_loaded, checked);
		$display("idling: back-to-back, sender gaps and receiver stalls of 0 to 16 cycles");
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/umhb_pkg.sv
src/umhb_csum_pipe.sv
src/umhb_serializer.sv
src/udp_multicast_header_builder_core.sv
sim/udp_multicast_header_checker.sv
sim/udp_multicast_header_builder_core_tb.sv
